// ----- hw/rtl/round_robin_budget_drain_top_assert.svh -----
// Assertion macros for the round-robin budget drain block.
// Used by the port checker; expects clk and rst_n in the calling scope.
`ifndef ROUND_ROBIN_BUDGET_DRAIN_TOP_ASSERT_SVH
`define ROUND_ROBIN_BUDGET_DRAIN_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RRBD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RRBD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rrbd_pkg.sv -----
// Shared constants for the round-robin budget drain block.
// No dependencies; used by the top level and the port checker.
package rrbd_pkg;

    localparam int VALUE_W   = 46;   // load count / run budget
    localparam int REM_W     = 40;   // remaining count on results
    localparam int S_TDATA_W = 48;   // value, padded to bytes
    localparam int S_TUSER_W = 1;    // req_type
    localparam int M_TDATA_W = 40;   // remaining

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

endpackage

// ----- hw/rtl/round_robin_budget_drain_top.sv -----
// Round-robin budget drain: queue count store, level search and result stream.
// Depends on rrbd_pkg and rrbd_ram.
//
// Channel  | Dir | Payload                              | Marks
// ---------+-----+--------------------------------------+----------------------------
// s_       | in  | tdata[45:0] value, tuser[0] req_type | 0 = load count, 1 = run
// m_       | out | tdata[39:0] remaining                | tlast on the last queue
//
// A run does a binary search over the pass level, up to ceil(log2(largest+1))
// steps; each step sweeps the count RAM through its one read port. Results then
// stream one per cycle while m_tready is high. Reset (rst_n low, async) empties
// the store; the count RAM needs no clearing pass. s_tready is high only while
// idle. m_ sits behind an output register, so a load or a new run is taken while
// the last result still waits for m_tready.
module round_robin_budget_drain_top #(
    parameter int MAX_QUEUES  = 64,
    parameter int COUNT_WIDTH = 40
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rrbd_pkg::S_TDATA_W-1:0]  s_tdata,   // [45:0] value, [47:46] zero
    input  logic [rrbd_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rrbd_pkg::M_TDATA_W-1:0]  m_tdata,   // [39:0] remaining
    output logic                            m_tlast
);
    import rrbd_pkg::*;

    localparam int AW   = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;  // RAM address
    localparam int NW   = $clog2(MAX_QUEUES + 1);                     // queue count
    localparam int CW   = COUNT_WIDTH;
    localparam int LW   = COUNT_WIDTH + 1;                            // level bounds
    localparam int SW   = COUNT_WIDTH + NW;                           // pass cost
    localparam int CMPW = (SW > VALUE_W) ? SW : VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,     // pick mid, or finish the search
        S_SWEEP,    // accumulate min(count, mid) over the store
        S_DECIDE,   // move lo or hi
        S_EMIT      // stream results
    } state_t;

    state_t            state_reg,    state_next;
    logic [NW-1:0]     n_reg,        n_next;
    logic [CW-1:0]     largest_reg,  largest_next;
    logic [LW-1:0]     lo_reg,       lo_next;
    logic [LW-1:0]     hi_reg,       hi_next;
    logic [LW-1:0]     mid_reg,      mid_next;
    logic [SW-1:0]     cost_lo_reg,  cost_lo_next;
    logic [SW-1:0]     acc_reg,      acc_next;
    logic [VALUE_W-1:0] budget_reg,  budget_next;
    logic [VALUE_W-1:0] spare_reg,   spare_next;
    logic [NW-1:0]     rd_idx_reg,   rd_idx_next;
    logic              dv_reg,       dv_next;
    logic [NW-1:0]     em_idx_reg,   em_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [REM_W-1:0]  out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    // RAM ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CW-1:0]     ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CW-1:0]     ram_rdata;

    // Datapath helpers
    logic [VALUE_W-1:0] value_in;
    logic [CW-1:0]      sat_cnt;
    logic [CW-1:0]      take;
    logic [LW-1:0]      diff;
    logic [NW-1:0]      em_nxt;
    logic               gt;
    logic               dec;
    logic [CW-1:0]      rem_cnt;
    logic               load_ok;

    rrbd_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_QUEUES)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign value_in = s_tdata[VALUE_W-1:0];
    // Counts above the store width saturate
    assign sat_cnt  = (|value_in[VALUE_W-1:CW]) ? {CW{1'b1}} : value_in[CW-1:0];

    // Sweep term: min(count, mid); mid never exceeds the largest count
    assign take = (LW'(ram_rdata) < mid_reg) ? ram_rdata : mid_reg[CW-1:0];

    assign diff   = hi_reg - lo_reg;
    assign em_nxt = em_idx_reg + NW'(1);

    // Emit: the earliest queues above the level take one leftover unit each, while spare lasts
    assign gt      = (LW'(ram_rdata) > lo_reg);
    assign dec     = gt && (spare_reg != '0);
    assign rem_cnt = gt ? (ram_rdata - lo_reg[CW-1:0] - CW'(dec)) : '0;
    assign load_ok = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        largest_next   = largest_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        cost_lo_next   = cost_lo_reg;
        acc_next       = acc_reg;
        budget_next    = budget_reg;
        spare_next     = spare_reg;
        rd_idx_next    = rd_idx_reg;
        dv_next        = 1'b0;
        em_idx_next    = em_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = n_reg[AW-1:0];
        ram_wdata = sat_cnt;
        ram_re    = 1'b0;
        ram_raddr = rd_idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == REQ_LOAD)
                    begin
                        if (n_reg != NW'(MAX_QUEUES))
                        begin
                            ram_we = 1'b1;
                            n_next = n_reg + NW'(1);
                            if (sat_cnt > largest_reg)
                            begin
                                largest_next = sat_cnt;
                            end
                        end
                    end
                    else if (n_reg != '0)
                    begin
                        budget_next  = value_in;
                        lo_next      = '0;
                        hi_next      = LW'(largest_reg) + LW'(1);
                        cost_lo_next = '0;
                        state_next   = S_STEP;
                    end
                end
            end

            S_STEP:
            begin
                if (diff > LW'(1))
                begin
                    mid_next    = lo_reg + (diff >> 1);
                    acc_next    = '0;
                    rd_idx_next = '0;
                    state_next  = S_SWEEP;
                end
                else
                begin
                    // Level settled: leftover budget after lo full passes
                    spare_next  = VALUE_W'(CMPW'(budget_reg) - CMPW'(cost_lo_reg));
                    ram_re      = 1'b1;
                    ram_raddr   = '0;
                    em_idx_next = '0;
                    state_next  = S_EMIT;
                end
            end

            S_SWEEP:
            begin
                ram_re = (rd_idx_reg != n_reg);
                if (ram_re)
                begin
                    rd_idx_next = rd_idx_reg + NW'(1);
                end
                dv_next = ram_re;
                if (dv_reg)
                begin
                    acc_next = acc_reg + SW'(take);
                    if (!ram_re)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                if (CMPW'(acc_reg) <= CMPW'(budget_reg))
                begin
                    lo_next      = mid_reg;
                    cost_lo_next = acc_reg;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_STEP;
            end

            S_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = REM_W'(rem_cnt);
                    out_last_next  = (em_nxt == n_reg);
                    if (dec)
                    begin
                        spare_next = spare_reg - VALUE_W'(1);
                    end
                    if (em_nxt == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // RAM data holds until this read replaces it
                        em_idx_next = em_nxt;
                        ram_re      = 1'b1;
                        ram_raddr   = em_nxt[AW-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            largest_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            cost_lo_reg   <= '0;
            acc_reg       <= '0;
            budget_reg    <= '0;
            spare_reg     <= '0;
            rd_idx_reg    <= '0;
            dv_reg        <= 1'b0;
            em_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            largest_reg   <= largest_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            cost_lo_reg   <= cost_lo_next;
            acc_reg       <= acc_next;
            budget_reg    <= budget_next;
            spare_reg     <= spare_next;
            rd_idx_reg    <= rd_idx_next;
            dv_reg        <= dv_next;
            em_idx_reg    <= em_idx_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

// ----- hw/rtl/rrbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read data holds when no read is issued. No dependencies.
module rrbd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/rrbd_checker.sv -----
// Port-level checker for the round-robin budget drain block, bound to the top.
// Depends on rrbd_pkg and round_robin_budget_drain_top_assert.svh.
`include "round_robin_budget_drain_top_assert.svh"

module rrbd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rrbd_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rrbd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);
    import rrbd_pkg::*;

    // Stalled result holds
    `RRBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // A load completes in its accept cycle
    `RRBD_ASSERT_NEXT(a_load_one_cycle, s_tvalid && s_tready && (s_tuser[0] == REQ_LOAD), s_tready, "load did not return to idle")

    // Mid-run results mean the block is busy
    `RRBD_ASSERT_SAME(a_busy_mid_run, m_tvalid && m_tready && !m_tlast, !s_tready, "input taken during a run")

endmodule

bind round_robin_budget_drain_top rrbd_checker u_rrbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for round_robin_budget_drain_top.
// Needs rrbd_pkg and the block's RTL; drives the s_ stream and checks every m_ item
// against typed results or a built-in model of the round-robin drain.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrbd_pkg::*;

    localparam int          MAX_Q        = 64;
    localparam logic [45:0] VALUE_MAX    = '1;
    localparam logic [39:0] COUNT_TOP    = '1;
    localparam int          BY_MODEL     = -1;     // row is checked against the model
    localparam int          RANDOM_ITEMS = 237;
    localparam int          STALL_LIMIT  = 20000;  // idle cycles before the watchdog trips
    localparam int          HOLD_CYCLES  = 600;    // one long receiver hold-off
    localparam int          TAIL_CYCLES  = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    round_robin_budget_drain_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [45:0] value, [47:46] zero
        .s_tuser  (s_tuser),   // [0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [39:0] remaining
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Drain model: its own copy of the queue store.
    // ------------------------------------------------------------------
    typedef struct {
        logic [39:0] remaining;
        logic        last;
    } drain_result_t;

    logic [39:0]   count_store [MAX_Q];
    int            stored_n = 0;
    logic [39:0]   peak_count = '0;
    drain_result_t drain_expect [$];

    int errors       = 0;
    int results_seen = 0;

    // Cost of 'passes' full round-robin passes: sum of min(count, passes).
    function automatic logic [63:0] level_cost(input logic [63:0] passes);
        logic [63:0] sum;
        sum = '0;
        for (int i = 0; i < stored_n; i++)
            sum += ({24'd0, count_store[i]} < passes) ? {24'd0, count_store[i]} : passes;
        return sum;
    endfunction

    // Returns 1 when the load lands in the store, 0 when the store is full.
    function automatic bit load_count(input logic [45:0] value);
        logic [39:0] sat;
        if (stored_n >= MAX_Q)
            return 1'b0;
        sat = (value > {6'd0, COUNT_TOP}) ? COUNT_TOP : value[39:0];
        count_store[stored_n] = sat;
        stored_n++;
        if (sat > peak_count)
            peak_count = sat;
        return 1'b1;
    endfunction

    // Level search, spare spending and result generation for one run item.
    function automatic void predict_drain(input logic [45:0] budget);
        logic [63:0] lo, hi, mid, spare;
        logic [39:0] work [MAX_Q];
        drain_result_t r;
        if (stored_n == 0)
            return;                         // empty run: nothing comes out
        lo = '0;
        hi = {24'd0, peak_count} + 64'd1;
        while (hi - lo > 64'd1)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (level_cost(mid) <= {18'd0, budget})
                lo = mid;
            else
                hi = mid;
        end
        spare = {18'd0, budget} - level_cost(lo);
        for (int i = 0; i < stored_n; i++)
            work[i] = count_store[i];
        // leftover units go one each to the earliest queues still above the level
        for (int i = 0; i < stored_n && spare != 0; i++)
        begin
            if ({24'd0, work[i]} > lo)
            begin
                work[i] = work[i] - 40'd1;
                spare   = spare - 64'd1;
            end
        end
        for (int i = 0; i < stored_n; i++)
        begin
            r.remaining = ({24'd0, work[i]} > lo) ? work[i] - lo[39:0] : 40'd0;
            r.last      = (i == stored_n - 1);
            drain_expect.push_back(r);
        end
    endfunction

    // Random budget: mostly around the cost of some level so the search lands
    // anywhere in the store, plus edges around the total and small or wide picks.
    function automatic logic [45:0] pick_budget();
        logic [63:0] lvl, b, total;
        int          mode;
        mode = $urandom_range(0, 99);
        if (stored_n == 0 || mode < 10)
            return 46'($urandom_range(0, 300));
        if (mode < 20)
            return {14'($urandom_range(0, 16'h3FFF)), 32'($urandom())};
        total = level_cost({24'd0, peak_count});
        if (mode < 30)
            b = total + 64'($urandom_range(0, 5));
        else if (mode < 36)
            b = total - ((total > 64'd3) ? 64'($urandom_range(0, 3)) : 64'd0);
        else
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                lvl = {24'd0, count_store[$urandom_range(0, stored_n - 1)]};
                lvl = lvl + 64'($urandom_range(0, 2));
                lvl = (lvl > 64'd0) ? lvl - 64'd1 : lvl;
            end
            else
                lvl = {$urandom(), $urandom()} % ({24'd0, peak_count} + 64'd1);
            b = level_cost(lvl) + 64'($urandom_range(0, stored_n + 2));
        end
        return (b > {18'd0, VALUE_MAX}) ? VALUE_MAX : b[45:0];
    endfunction

    function automatic logic [45:0] pick_count();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 25)
            return 46'($urandom_range(0, 20));
        if (mode < 50)
            return 46'($urandom_range(0, 1000));
        if (mode < 85)
            return {6'd0, 8'($urandom()), 32'($urandom())};
        return {14'($urandom_range(0, 16'h3FFF)), 32'($urandom())};   // mostly saturates
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. Runs whose outcome is obvious carry their results;
    // BY_MODEL rows go through the model. n_typed is unused on loads.
    // ------------------------------------------------------------------
    typedef struct {
        logic        req;
        logic [45:0] value;
        int          n_typed;
        logic [39:0] rem [3];
    } stim_row_t;

    localparam int N_DIR = 23;
    stim_row_t dir_rows [N_DIR] = '{
        '{REQ_RUN,  46'd0,                0,        '{40'd0, 40'd0, 40'd0}},  // empty run
        '{REQ_RUN,  VALUE_MAX,            0,        '{40'd0, 40'd0, 40'd0}},  // empty run
        '{REQ_LOAD, 46'd5,                0,        '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'd0,                1,        '{40'd5, 40'd0, 40'd0}},
        '{REQ_RUN,  VALUE_MAX,            1,        '{40'd0, 40'd0, 40'd0}},  // over total
        '{REQ_LOAD, VALUE_MAX,            0,        '{40'd0, 40'd0, 40'd0}},  // saturates
        '{REQ_RUN,  46'd0,                2,        '{40'd5, COUNT_TOP, 40'd0}},
        '{REQ_LOAD, 46'd0,                0,        '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'd0,                3,        '{40'd5, COUNT_TOP, 40'd0}},
        '{REQ_RUN,  46'd3,                BY_MODEL, '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'h100_0000_0004,    3,        '{40'd0, 40'd0, 40'd0}},  // exact total
        '{REQ_RUN,  46'h100_0000_0003,    BY_MODEL, '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'h2AAA_AAAA_AAAA,   BY_MODEL, '{40'd0, 40'd0, 40'd0}},
        '{REQ_LOAD, 46'h00FF_FFFF_FFFF,   0,        '{40'd0, 40'd0, 40'd0}},  // top of range
        '{REQ_LOAD, 46'h0100_0000_0000,   0,        '{40'd0, 40'd0, 40'd0}},  // one above
        '{REQ_LOAD, 46'h1555_5555_5555,   0,        '{40'd0, 40'd0, 40'd0}},
        '{REQ_LOAD, 46'd1,                0,        '{40'd0, 40'd0, 40'd0}},
        '{REQ_LOAD, 46'd2,                0,        '{40'd0, 40'd0, 40'd0}},
        '{REQ_LOAD, 46'h00AA_AAAA_AAAA,   0,        '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'd7,                BY_MODEL, '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'h1555_5555_5555,   BY_MODEL, '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'h0000_8000_0000,   BY_MODEL, '{40'd0, 40'd0, 40'd0}},
        '{REQ_RUN,  46'h3FFF_FFFF_FFFE,   BY_MODEL, '{40'd0, 40'd0, 40'd0}}
    };

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Hold the item on s_ until the block takes it. s_tready is sampled as it
    // stood at the edge, so the handshake is decided free of races.
    task automatic offer_item(input logic req, input logic [45:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, value};
        do @(posedge clk); while (!s_tready);
    endtask

    // Random gaps before an item, each added with an 11 in 100 chance; none when quiet.
    task automatic sender_gaps(input bit quiet);
        while (!quiet && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop tvalid, then wait for every pending result.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (drain_expect.size() != 0);
    endtask

    initial
    begin
        int          counted;
        logic        req;
        logic [45:0] value;
        drain_result_t r;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int k = 0; k < N_DIR; k++)
        begin
            sender_gaps(1'b0);
            offer_item(dir_rows[k].req, dir_rows[k].value);
            if (dir_rows[k].req == REQ_LOAD)
                void'(load_count(dir_rows[k].value));
            else if (dir_rows[k].n_typed == BY_MODEL)
                predict_drain(dir_rows[k].value);
            else
                for (int i = 0; i < dir_rows[k].n_typed; i++)
                begin
                    r.remaining = dir_rows[k].rem[i];
                    r.last      = (i == dir_rows[k].n_typed - 1);
                    drain_expect.push_back(r);
                end
        end
        wait_drained();

        // random part: fills the store while running at every size, then
        // keeps running on the full store with a few ignored loads mixed in
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            sender_gaps(counted >= 110 && counted < 160);
            if (counted == 60 || counted == 180 || $urandom_range(0, 99) < 2)
                wait_drained();
            if (stored_n < MAX_Q ? ($urandom_range(0, 99) < 55) : ($urandom_range(0, 99) < 6))
            begin
                req   = REQ_LOAD;
                value = pick_count();
            end
            else
            begin
                req   = REQ_RUN;
                value = pick_budget();
            end
            offer_item(req, value);
            if (req == REQ_LOAD)
            begin
                if (load_count(value))
                    counted++;
            end
            else
            begin
                predict_drain(value);
                counted++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);   // anything arriving now is unexpected
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: checks each accepted item, then picks m_tready for the
    // next edge. One long hold-off once the first runs are flowing, and a
    // stretch with tready held high.
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    task automatic check_drain_item();
        drain_result_t want;
        if (drain_expect.size() == 0)
        begin
            $error("unexpected item: remaining %0d last %0b", m_tdata, m_tlast);
            errors++;
            return;
        end
        want = drain_expect.pop_front();
        if (m_tdata[39:0] !== want.remaining)
        begin
            $error("remaining: expected %0d, got %0d", want.remaining, m_tdata[39:0]);
            errors++;
        end
        if (m_tlast !== want.last)
        begin
            $error("is_last: expected %0b, got %0b", want.last, m_tlast);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_drain_item();
            results_seen++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 200)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (results_seen >= 2000 && results_seen < 5000)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 11);
    end

    // Watchdog: a run over the largest counts searches with no item moving on either
    // stream; the limit covers that plus the hold-off several times over.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
